// ===== rtl/rlsfd_pkg.sv =====
package rlsfd_pkg;

  localparam int MAX_LEDS = 256;
  localparam int ROW_W = $clog2(MAX_LEDS);
  localparam int COUNT_W = $clog2(MAX_LEDS + 1);

  localparam int OP_W = 2;
  localparam int PIX_W = 8;
  localparam int POS_W = 8;
  localparam int TICK_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [OP_W-1:0] OP_WHEEL = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd4;

  typedef struct packed {
    logic write_pixel;
    logic start_fetch;
    logic next_fetch;
    logic tick_step;
    logic load_byte;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic tick_fetch;
  } status_t;

endpackage

// ===== rtl/rlsfd_item_if.sv =====
interface rlsfd_item_if import rlsfd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [PIX_W-1:0] pixel_index;
  logic [POS_W-1:0] wheel_pos;

  modport source (output valid, output operation, output pixel_index, output wheel_pos,
                  input ready);
  modport sink (input valid, input operation, input pixel_index, input wheel_pos,
                output ready);
endinterface

// ===== rtl/rlsfd_result_if.sv =====
interface rlsfd_result_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output pin_level, output busy_res, output frame_done,
                  input ready);
  modport sink (input valid, input pin_level, input busy_res, input frame_done,
                output ready);
endinterface

// ===== rtl/rlsfd_cfg_if.sv =====
interface rlsfd_cfg_if import rlsfd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rlsfd_datapath.sv =====
module rlsfd_datapath import rlsfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PIX_W-1:0]      pixel_index,
  input  logic [POS_W-1:0]      wheel_pos,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  pin_level,
  output logic                  busy_res,
  output logic                  frame_done
);

  localparam logic [1:0] LANE_G = 2'd0;
  localparam logic [1:0] LANE_R = 2'd1;
  localparam logic [1:0] LANE_B = 2'd2;
  localparam logic [POS_W-1:0] SEG_LEN = 8'd85;
  localparam logic [POS_W-1:0] SEG_TWO = 8'd170;
  localparam logic [7:0] FULL = 8'd255;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [23:0] wheel_row(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] seg;
    logic [7:0] up;
    logic [7:0] down;
    logic [23:0] row_val;
    if (pos < SEG_LEN) begin
      seg = pos;
    end else if (pos < SEG_TWO) begin
      seg = pos - SEG_LEN;
    end else begin
      seg = pos - SEG_TWO;
    end
    up = 8'({1'b0, seg, 1'b0} + {2'b00, seg});
    down = FULL - up;
    if (pos < SEG_LEN) begin
      row_val = {8'd0, down, up};
    end else if (pos < SEG_TWO) begin
      row_val = {up, 8'd0, down};
    end else begin
      row_val = {down, up, 8'd0};
    end
    return row_val;
  endfunction

  logic [TICK_W-1:0]  one_high;
  logic [TICK_W-1:0]  one_low;
  logic [TICK_W-1:0]  zero_high;
  logic [TICK_W-1:0]  zero_low;
  logic [COUNT_W-1:0] led_count;
  logic [COUNT_W-1:0] eff_count;

  logic [23:0] frame_mem [MAX_LEDS];
  logic [23:0] rd_data;
  logic [ROW_W-1:0] rd_addr;
  logic [7:0] rd_byte;
  logic mem_we;

  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [1:0] lane;
  logic [1:0] lane_next;
  logic [7:0] shift_byte;
  logic [7:0] shift_byte_next;
  logic [2:0] bit_index;
  logic [2:0] bit_index_next;
  logic in_high;
  logic in_high_next;
  logic [TICK_W-1:0] phase_counter;
  logic [TICK_W-1:0] phase_counter_next;
  logic sending;
  logic sending_next;
  logic done_next;
  logic count_more;
  logic byte_end;
  logic [7:0] shifted;

  assign eff_count = (led_count > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS) : led_count;
  assign mem_we = cmd.write_pixel && ({1'b0, pixel_index} < eff_count);
  assign rd_addr = cmd.start_fetch ? '0 :
                   (lane == LANE_B) ? ROW_W'(row + 1'b1) : row;
  assign count_more = (lane == LANE_B) ? (({1'b0, row} + 1'b1) < eff_count)
                                       : ({1'b0, row} < eff_count);
  assign byte_end = sending && (phase_counter <= TICK_W'(1)) && !in_high
                    && (bit_index == 3'd7);
  assign status.tick_fetch = byte_end && count_more;
  assign status.start_ok = !sending && (eff_count != '0);
  assign shifted = {shift_byte[6:0], 1'b0};

  always_comb begin
    unique case (lane)
      LANE_G: rd_byte = rd_data[23:16];
      LANE_R: rd_byte = rd_data[15:8];
      LANE_B: rd_byte = rd_data[7:0];
      default: rd_byte = 8'd0;
    endcase
  end

  always_comb begin
    row_next = row;
    lane_next = lane;
    shift_byte_next = shift_byte;
    bit_index_next = bit_index;
    in_high_next = in_high;
    phase_counter_next = phase_counter;
    sending_next = sending;
    done_next = 1'b0;
    if (cmd.start_fetch) begin
      row_next = '0;
      lane_next = LANE_G;
    end
    if (cmd.next_fetch) begin
      if (lane == LANE_B) begin
        row_next = ROW_W'(row + 1'b1);
        lane_next = LANE_G;
      end else begin
        lane_next = lane + 2'd1;
      end
    end
    if (cmd.load_byte) begin
      shift_byte_next = rd_byte;
      bit_index_next = 3'd0;
      in_high_next = 1'b1;
      phase_counter_next = at_least_one(rd_byte[7] ? one_high : zero_high);
      sending_next = 1'b1;
    end
    if (cmd.tick_step && sending) begin
      if (phase_counter > TICK_W'(1)) begin
        phase_counter_next = phase_counter - 1'b1;
      end else if (in_high) begin
        in_high_next = 1'b0;
        phase_counter_next = at_least_one(shift_byte[7] ? one_low : zero_low);
      end else if (bit_index != 3'd7) begin
        shift_byte_next = shifted;
        bit_index_next = bit_index + 3'd1;
        in_high_next = 1'b1;
        phase_counter_next = at_least_one(shifted[7] ? one_high : zero_high);
      end else begin
        shift_byte_next = shifted;
        sending_next = 1'b0;
        in_high_next = 1'b0;
        phase_counter_next = '0;
        bit_index_next = 3'd0;
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[pixel_index] <= wheel_row(wheel_pos);
    end
    if (cmd.start_fetch || cmd.next_fetch) begin
      rd_data <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high <= TICK_W'(19);
      one_low <= TICK_W'(11);
      zero_high <= TICK_W'(10);
      zero_low <= TICK_W'(20);
      led_count <= COUNT_W'(MAX_LEDS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_HIGH: one_high <= cfg_data[TICK_W-1:0];
        REG_ONE_LOW: one_low <= cfg_data[TICK_W-1:0];
        REG_ZERO_HIGH: zero_high <= cfg_data[TICK_W-1:0];
        REG_ZERO_LOW: zero_low <= cfg_data[TICK_W-1:0];
        REG_LED_COUNT: led_count <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      lane <= LANE_G;
      shift_byte <= '0;
      bit_index <= '0;
      in_high <= 1'b0;
      phase_counter <= '0;
      sending <= 1'b0;
    end else begin
      row <= row_next;
      lane <= lane_next;
      shift_byte <= shift_byte_next;
      bit_index <= bit_index_next;
      in_high <= in_high_next;
      phase_counter <= phase_counter_next;
      sending <= sending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pin_level <= sending_next && in_high_next;
      busy_res <= sending_next;
      frame_done <= done_next;
    end
  end

endmodule

// ===== rtl/rlsfd_controller.sv =====
module rlsfd_controller import rlsfd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] operation,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  status_t         status,
  output cmd_t            cmd
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;
  logic fetch;

  assign in_ready = (state == ST_RUN) && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd.write_pixel = accept && (operation == OP_WHEEL);
    cmd.start_fetch = accept && (operation == OP_START) && status.start_ok;
    cmd.next_fetch = accept && (operation == OP_TICK) && status.tick_fetch;
    cmd.tick_step = accept && (operation == OP_TICK) && !status.tick_fetch;
    cmd.load_byte = (state == ST_LOAD);
    fetch = cmd.start_fetch || cmd.next_fetch;
    cmd.capture = (accept && !fetch) || (state == ST_LOAD);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (fetch) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    priority if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // The result register is always free while the frame memory read completes.
  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !out_valid)
    else $error("result pending during byte load");

  a_fetch_to_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_fetch || cmd.next_fetch) |=> (state == ST_LOAD))
    else $error("memory fetch not followed by byte load");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_RUN) && out_valid)
    else $error("byte load did not produce a result");

endmodule

// ===== rtl/rgb_led_serial_frame_driver_top.sv =====
// Serial RGB LED frame driver.
// The items channel carries one request per item: a wheel pixel write, a frame
// start or one time tick. Every request produces exactly one result on the
// results channel with the line level, the busy flag and the frame done pulse.
// The cfg channel writes the four bit timing registers and the LED count; it
// is always ready and must only be used while no request is outstanding.
// Each result is registered. A frame start that begins a frame, and the tick
// that ends a byte while more bytes follow, go through a byte load state,
// because the next byte is read from the registered frame memory first. All
// other requests sustain one per cycle while results are taken. A new request
// is accepted while the previous result is being taken.
// When the receiver stalls, the result is held and no further request is taken.
// Reset clears the sending state and restores the register
// defaults. The frame memory is not cleared; pixels must be written before use.
module rgb_led_serial_frame_driver_top import rlsfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rlsfd_item_if.sink     items,
  rlsfd_result_if.source results,
  rlsfd_cfg_if.sink      cfg
);

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  rlsfd_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .operation (items.operation),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rlsfd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .pixel_index (items.pixel_index),
    .wheel_pos   (items.wheel_pos),
    .cmd         (cmd),
    .status      (status),
    .pin_level   (results.pin_level),
    .busy_res    (results.busy_res),
    .frame_done  (results.frame_done)
  );

endmodule
